[design/lpm_pkg.sv]
// Shared types and constants for the latency percentile monitor.
`default_nettype none

package lpm_pkg;

  // Port field widths
  localparam int unsigned FUNC_W          = 2;
  localparam int unsigned TIME_W          = 48;
  localparam int unsigned SAMPLE_TOTAL_W  = 10;
  localparam int unsigned PENDING_TOTAL_W = 9;
  localparam int unsigned DROP_W          = 32;

  // Scratch widths for zero-extension before trimming to a port width
  localparam int unsigned WIDE_W    = 64;
  localparam int unsigned CNT_EXT_W = 32;

  // Event kinds carried on func
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SUBMIT   = 2'd0,
    FUNC_COMPLETE = 2'd1,
    FUNC_REPORT   = 2'd2,
    FUNC_UNUSED   = 2'd3
  } func_e;

endpackage

`default_nettype wire

[design/lpm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lpm_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/lpm_cell.sv]
// One cell of the sorting chain: keeps the smaller value, passes the larger on.
`default_nettype none

module lpm_cell #(
  parameter int unsigned WIDTH = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic             tok_vld_i,
  input  logic [WIDTH-1:0] tok_val_i,
  input  logic             nxt_vld_i,
  input  logic [WIDTH-1:0] nxt_val_i,
  output logic             tok_vld_o,
  output logic [WIDTH-1:0] tok_val_o,
  output logic             vld_o,
  output logic [WIDTH-1:0] val_o
);

  logic             vld_q, vld_d;
  logic [WIDTH-1:0] val_q, val_d;
  logic             tok_vld_q, tok_vld_d;
  logic [WIDTH-1:0] tok_val_q, tok_val_d;

  // Insert, compare-exchange, or shift toward the head
  always_comb begin
    vld_d     = vld_q;
    val_d     = val_q;
    tok_vld_d = 1'b0;
    tok_val_d = tok_val_q;
    if (shift_i) begin
      vld_d = nxt_vld_i;
      val_d = nxt_val_i;
    end else if (tok_vld_i) begin
      if (!vld_q) begin
        vld_d = 1'b1;
        val_d = tok_val_i;
      end else if (tok_val_i < val_q) begin
        val_d     = tok_val_i;
        tok_vld_d = 1'b1;
        tok_val_d = val_q;
      end else begin
        tok_vld_d = 1'b1;
        tok_val_d = tok_val_i;
      end
    end
  end

  // Hold control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      vld_q     <= vld_d;
      tok_vld_q <= tok_vld_d;
    end
  end

  // Hold data
  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    tok_val_q <= tok_val_d;
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_val_o = tok_val_q;
  assign vld_o     = vld_q;
  assign val_o     = val_q;

endmodule

`default_nettype wire

[design/lpm_chain.sv]
// Row of sorting cells holding the latency samples in ascending order.
`default_nettype none

module lpm_chain #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ins_vld_i,
  input  logic [WIDTH-1:0] ins_val_i,
  input  logic             shift_i,
  output logic [WIDTH-1:0] head_val_o
);

  logic             ins_vld_q;
  logic [WIDTH-1:0] ins_val_q;

  wire             tok_vld  [0:DEPTH];
  wire [WIDTH-1:0] tok_val  [0:DEPTH];
  wire             cell_vld [0:DEPTH];
  wire [WIDTH-1:0] cell_val [0:DEPTH];

  // Register the new sample before it enters the first cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ins_vld_q <= 1'b0;
    end else begin
      ins_vld_q <= ins_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_val_q <= ins_val_i;
  end

  assign tok_vld[0] = ins_vld_q;
  assign tok_val[0] = ins_val_q;

  // Empty slot shifted in past the last cell
  assign cell_vld[DEPTH] = 1'b0;
  assign cell_val[DEPTH] = '0;

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    lpm_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift_i),
      .tok_vld_i(tok_vld[gi]),
      .tok_val_i(tok_val[gi]),
      .nxt_vld_i(cell_vld[gi+1]),
      .nxt_val_i(cell_val[gi+1]),
      .tok_vld_o(tok_vld[gi+1]),
      .tok_val_o(tok_val[gi+1]),
      .vld_o    (cell_vld[gi]),
      .val_o    (cell_val[gi])
    );
  end

  assign head_val_o = cell_val[0];

endmodule

`default_nettype wire

[design/latency_percentile_monitor.sv]
// Latency monitor: pending-timestamp FIFO, sorting cell chain and report sequencer.
// Submit completes in ST_IDLE; completion reads the pending RAM (registered) and forms
// the sample in ST_COMP. A report waits in ST_DRAIN for the last insertion to settle in
// the cell chain, shifts samples out of the chain head in ST_SHIFT, then loads the result
// register in ST_PUT; a report with no samples goes straight to ST_PUT.
// Reset is asynchronous, active low, clears all control state; no clearing pass.
`default_nettype none

module latency_percentile_monitor #(
  parameter int unsigned PENDING_DEPTH = 256,
  parameter int unsigned SAMPLE_DEPTH  = 512,
  parameter int unsigned TIME_BITS     = 48
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [lpm_pkg::FUNC_W-1:0]           func_i,
  input  logic [lpm_pkg::TIME_W-1:0]           time_ns_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 has_samples_o,
  output logic [lpm_pkg::TIME_W-1:0]           median_ns_o,
  output logic [lpm_pkg::TIME_W-1:0]           p95_ns_o,
  output logic [lpm_pkg::TIME_W-1:0]           max_ns_o,
  output logic [lpm_pkg::SAMPLE_TOTAL_W-1:0]   sample_total_o,
  output logic [lpm_pkg::PENDING_TOTAL_W-1:0]  pending_total_o,
  output logic [lpm_pkg::DROP_W-1:0]           dropped_total_o
);

  import lpm_pkg::*;

  localparam int unsigned PA_W  = $clog2(PENDING_DEPTH);
  localparam int unsigned PC_W  = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned SUM_W = PA_W + 1;
  localparam int unsigned SA_W  = $clog2(SAMPLE_DEPTH);
  localparam int unsigned SC_W  = $clog2(SAMPLE_DEPTH + 1);
  localparam int unsigned M19_W = SA_W + 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_DRAIN,
    ST_SHIFT,
    ST_PUT
  } state_e;

  state_e                state_q;
  logic                  enable_q;
  logic [PA_W-1:0]       pend_head_q;
  logic [PC_W-1:0]       pend_cnt_q;
  logic [SC_W-1:0]       samp_cnt_q;
  logic [DROP_W-1:0]     drop_q;
  logic [SC_W-1:0]       drain_q;
  logic [TIME_BITS-1:0]  time_q;
  logic [SA_W-1:0]       idx_q;
  logic [SA_W-1:0]       last_q;
  logic [M19_W-1:0]      m19_q;
  logic [M19_W-1:0]      acc_q;
  logic [TIME_BITS-1:0]  med_q;
  logic [TIME_BITS-1:0]  p95_q;
  logic [TIME_BITS-1:0]  max_q;

  logic                       out_valid_q;
  logic                       has_samples_q;
  logic [TIME_W-1:0]          median_q;
  logic [TIME_W-1:0]          p95_out_q;
  logic [TIME_W-1:0]          max_out_q;
  logic [SAMPLE_TOTAL_W-1:0]  sample_total_q;
  logic [PENDING_TOTAL_W-1:0] pending_total_q;
  logic [DROP_W-1:0]          dropped_total_q;

  logic                 in_acc;
  func_e                func;
  logic [WIDE_W-1:0]    t_ext;
  logic [TIME_BITS-1:0] t_in;
  logic [SUM_W-1:0]     tail_sum;
  logic [SUM_W-1:0]     tail_wrap;
  logic [PA_W-1:0]      tail;
  logic                 pend_full;
  logic                 pend_empty;
  logic                 ram_we;
  logic                 ram_re;
  logic [TIME_BITS-1:0] start;
  logic                 later;
  logic [TIME_BITS-1:0] diff;
  logic                 samp_full;
  logic                 ins_vld;
  logic                 shift;
  logic [TIME_BITS-1:0] head_val;
  logic [SC_W-1:0]      cnt_m1;
  logic [SA_W-1:0]      last_idx;
  logic [M19_W-1:0]     m19_d;
  logic [M19_W-1:0]     acc_next;
  logic                 med_hit;
  logic                 p95_hit;
  logic                 max_hit;
  logic                 out_free;
  logic                 put_fire;
  logic [WIDE_W-1:0]    med_ext;
  logic [WIDE_W-1:0]    p95_ext;
  logic [WIDE_W-1:0]    max_ext;
  logic [CNT_EXT_W-1:0] samp_ext;
  logic [CNT_EXT_W-1:0] pend_ext;

  // Input handshake and timestamp width
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign func       = func_e'(func_i);
  assign t_ext      = WIDE_W'(time_ns_i);
  assign t_in       = t_ext[TIME_BITS-1:0];

  // Pending FIFO pointers
  assign tail_sum   = SUM_W'(pend_head_q) + SUM_W'(pend_cnt_q);
  assign tail_wrap  = (tail_sum >= SUM_W'(PENDING_DEPTH)) ?
                      (tail_sum - SUM_W'(PENDING_DEPTH)) : tail_sum;
  assign tail       = tail_wrap[PA_W-1:0];
  assign pend_full  = (pend_cnt_q == PC_W'(PENDING_DEPTH));
  assign pend_empty = (pend_cnt_q == '0);
  assign ram_we     = in_acc && enable_q && (func == FUNC_SUBMIT) && !pend_full;
  assign ram_re     = in_acc && enable_q && (func == FUNC_COMPLETE) && !pend_empty;

  lpm_ram #(
    .WIDTH(TIME_BITS),
    .DEPTH(PENDING_DEPTH)
  ) u_pend_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail),
    .wdata_i(t_in),
    .re_i   (ram_re),
    .raddr_i(pend_head_q),
    .rdata_o(start)
  );

  // Latency sample from the popped timestamp
  assign later     = (time_q > start);
  assign diff      = time_q - start;
  assign samp_full = (samp_cnt_q == SC_W'(SAMPLE_DEPTH));
  assign ins_vld   = (state_q == ST_COMP) && later && !samp_full;
  assign shift     = (state_q == ST_SHIFT);

  lpm_chain #(
    .WIDTH(TIME_BITS),
    .DEPTH(SAMPLE_DEPTH)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ins_vld_i (ins_vld),
    .ins_val_i (diff),
    .shift_i   (shift),
    .head_val_o(head_val)
  );

  // Rank selection while the sorted samples stream out of the chain head
  assign cnt_m1   = samp_cnt_q - SC_W'(1);
  assign last_idx = cnt_m1[SA_W-1:0];
  assign m19_d    = (M19_W'(last_idx) << 4) + (M19_W'(last_idx) << 1) + M19_W'(last_idx);
  assign acc_next = acc_q + M19_W'(20);
  assign med_hit  = (idx_q == (last_q >> 1));
  assign p95_hit  = (acc_q <= m19_q) && (m19_q < acc_next);
  assign max_hit  = (idx_q == last_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign put_fire = (state_q == ST_PUT) && out_free;

  // Trim to port widths
  assign med_ext  = WIDE_W'(med_q);
  assign p95_ext  = WIDE_W'(p95_q);
  assign max_ext  = WIDE_W'(max_q);
  assign samp_ext = CNT_EXT_W'(samp_cnt_q);
  assign pend_ext = CNT_EXT_W'(pend_cnt_q);

  // Sequencer, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      enable_q        <= 1'b0;
      pend_head_q     <= '0;
      pend_cnt_q      <= '0;
      samp_cnt_q      <= '0;
      drop_q          <= '0;
      drain_q         <= '0;
      time_q          <= '0;
      idx_q           <= '0;
      last_q          <= '0;
      m19_q           <= '0;
      acc_q           <= '0;
      med_q           <= '0;
      p95_q           <= '0;
      max_q           <= '0;
      out_valid_q     <= 1'b0;
      has_samples_q   <= 1'b0;
      median_q        <= '0;
      p95_out_q       <= '0;
      max_out_q       <= '0;
      sample_total_q  <= '0;
      pending_total_q <= '0;
      dropped_total_q <= '0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      // Raise the result on a load, drop it once taken
      if (put_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // Restart the settle count on each insertion, else count down
      if (ins_vld) begin
        drain_q <= samp_cnt_q + SC_W'(1);
      end else if (drain_q != '0) begin
        drain_q <= drain_q - SC_W'(1);
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc && enable_q) begin
            case (func)
              FUNC_SUBMIT: begin
                if (pend_full) begin
                  if (drop_q != '1) begin
                    drop_q <= drop_q + DROP_W'(1);
                  end
                end else begin
                  pend_cnt_q <= pend_cnt_q + PC_W'(1);
                end
              end
              FUNC_COMPLETE: begin
                if (!pend_empty) begin
                  time_q      <= t_in;
                  pend_cnt_q  <= pend_cnt_q - PC_W'(1);
                  pend_head_q <= (pend_head_q == PA_W'(PENDING_DEPTH - 1)) ?
                                 '0 : pend_head_q + PA_W'(1);
                  state_q     <= ST_COMP;
                end
              end
              FUNC_REPORT: begin
                state_q <= (samp_cnt_q == '0) ? ST_PUT : ST_DRAIN;
              end
              default: begin
              end
            endcase
          end
        end

        ST_COMP: begin
          if (ins_vld) begin
            samp_cnt_q <= samp_cnt_q + SC_W'(1);
          end
          state_q <= ST_IDLE;
        end

        ST_DRAIN: begin
          // Wait for the last insertion to settle in the chain
          if (drain_q == '0) begin
            idx_q   <= '0;
            acc_q   <= '0;
            last_q  <= last_idx;
            m19_q   <= m19_d;
            state_q <= ST_SHIFT;
          end
        end

        ST_SHIFT: begin
          if (med_hit) begin
            med_q <= head_val;
          end
          if (p95_hit) begin
            p95_q <= head_val;
          end
          if (max_hit) begin
            max_q   <= head_val;
            state_q <= ST_PUT;
          end else begin
            idx_q <= idx_q + SA_W'(1);
            acc_q <= acc_next;
          end
        end

        ST_PUT: begin
          if (out_free) begin
            has_samples_q   <= (samp_cnt_q != '0);
            sample_total_q  <= samp_ext[SAMPLE_TOTAL_W-1:0];
            pending_total_q <= pend_ext[PENDING_TOTAL_W-1:0];
            dropped_total_q <= drop_q;
            if (samp_cnt_q != '0) begin
              median_q   <= med_ext[TIME_W-1:0];
              p95_out_q  <= p95_ext[TIME_W-1:0];
              max_out_q  <= max_ext[TIME_W-1:0];
              samp_cnt_q <= '0;
              drop_q     <= '0;
            end else begin
              median_q  <= '0;
              p95_out_q <= '0;
              max_out_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign has_samples_o   = has_samples_q;
  assign median_ns_o     = median_q;
  assign p95_ns_o        = p95_out_q;
  assign max_ns_o        = max_out_q;
  assign sample_total_o  = sample_total_q;
  assign pending_total_o = pending_total_q;
  assign dropped_total_o = dropped_total_q;

endmodule

`default_nettype wire

[design/lpm_checker.sv]
// Port-level checks for the latency percentile monitor, bound to the top level.
`default_nettype none

module lpm_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_ready_o,
  input  logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  input  logic                                 has_samples_o,
  input  logic [lpm_pkg::TIME_W-1:0]           median_ns_o,
  input  logic [lpm_pkg::TIME_W-1:0]           p95_ns_o,
  input  logic [lpm_pkg::TIME_W-1:0]           max_ns_o,
  input  logic [lpm_pkg::SAMPLE_TOTAL_W-1:0]   sample_total_o,
  input  logic [lpm_pkg::PENDING_TOTAL_W-1:0]  pending_total_o,
  input  logic [lpm_pkg::DROP_W-1:0]           dropped_total_o
);

  // Hold a stalled result transaction unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(median_ns_o) && $stable(p95_ns_o) && $stable(max_ns_o)
       && $stable(sample_total_o) && $stable(dropped_total_o)
       && $stable(pending_total_o) && $stable(has_samples_o)))
    else $error("result changed while stalled");

  // Empty report carries zero statistics
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_samples_o) |->
      (median_ns_o == '0 && p95_ns_o == '0 && max_ns_o == '0 && sample_total_o == '0))
    else $error("empty report with nonzero statistics");

  // Percentiles come out ordered
  a_rank_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_samples_o) |->
      (sample_total_o != '0 && median_ns_o <= p95_ns_o && p95_ns_o <= max_ns_o))
    else $error("report statistics out of order");

  // A new result is produced only while input is held off by the report
  a_report_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while input was open");

endmodule

bind latency_percentile_monitor lpm_checker u_lpm_checker (.*);

`default_nettype wire
